// File: hw/rtl/b2pe_pkg.sv
// Shared types, constants and helpers for the two-dimensional parity block.
package b2pe_pkg;

   // Number of data bytes that take part in the parity, 1 to 8.
   localparam int BLOCK_BYTES = 8;

   localparam int BYTE_W  = 8;
   localparam int NUM_LANES = 8;
   localparam int DATA_W  = BYTE_W * NUM_LANES;
   localparam int CHECK_W = 2 * BYTE_W;

   // Row syndrome bits that name a byte inside the block.
   localparam logic [BYTE_W-1:0] ROW_IN_BLOCK = BYTE_W'((1 << BLOCK_BYTES) - 1);

   // Request codes.
   localparam logic MODE_GEN   = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_CLEAN  = 2'd0,
      STAT_CORR   = 2'd1,
      STAT_UNCORR = 2'd2
   } status_type;

   // Word leaving the parity stage.
   typedef struct packed {
      logic               valid;
      logic               mode;
      logic [DATA_W-1:0]  data;
      logic [CHECK_W-1:0] rcv;
      logic [CHECK_W-1:0] chk;
   } par_stage_type;

   // Word leaving the locate stage.
   typedef struct packed {
      logic               valid;
      logic [DATA_W-1:0]  data;
      logic [CHECK_W-1:0] chk;
      logic [DATA_W-1:0]  flip;
      status_type         status;
   } loc_stage_type;

   // True when exactly one bit of the byte is set.
   function automatic logic one_hot8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] m;
      m = v - BYTE_W'(1);
      return (v != '0) && ((v & m) == '0);
   endfunction

endpackage

// File: hw/rtl/b2pe_parity.sv
// First stage: register the request and form the check word over the block.
module b2pe_parity import b2pe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_mode,
   input  logic [DATA_W-1:0]  in_data,
   input  logic [CHECK_W-1:0] in_rcv,
   output par_stage_type      out_stage
);

   par_stage_type stage_ff;
   par_stage_type stage_in;
   logic [BYTE_W-1:0] col;
   logic [BYTE_W-1:0] row;

   // Column parity is the XOR of all block bytes; row bit i is the parity of byte i.
   always_comb begin
      col = '0;
      row = '0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         col    = col ^ in_data[i*BYTE_W +: BYTE_W];
         row[i] = ^in_data[i*BYTE_W +: BYTE_W];
      end
      stage_in.valid = in_valid;
      stage_in.mode  = in_mode;
      stage_in.data  = in_data;
      stage_in.rcv   = in_rcv;
      stage_in.chk   = {col, row};
   end

   // Only the valid bit is reset; the payload follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.mode <= stage_in.mode;
      stage_ff.data <= stage_in.data;
      stage_ff.rcv  <= stage_in.rcv;
      stage_ff.chk  <= stage_in.chk;
   end

   assign out_stage = stage_ff;

endmodule

// File: hw/rtl/b2pe_locate.sv
// Second stage: form the syndrome, classify it and build the bit flip mask.
module b2pe_locate import b2pe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  par_stage_type in_stage,
   output loc_stage_type out_stage
);

   loc_stage_type stage_ff;
   loc_stage_type stage_in;
   logic [CHECK_W-1:0] syn;
   logic [BYTE_W-1:0]  xs;
   logic [BYTE_W-1:0]  ys;
   logic               single;
   status_type         status;

   // The syndrome compares the received check word with the recomputed one.
   always_comb begin
      syn    = in_stage.rcv ^ in_stage.chk;
      xs     = syn[CHECK_W-1:BYTE_W];
      ys     = syn[BYTE_W-1:0];
      single = one_hot8(xs) && one_hot8(ys);
   end

   // Generate mode is always clean; a single bit inside the block is corrected.
   always_comb begin
      priority if (in_stage.mode == MODE_GEN) begin
         status = STAT_CLEAN;
      end else if (syn == '0) begin
         status = STAT_CLEAN;
      end else if (single && ((ys & ROW_IN_BLOCK) != '0)) begin
         status = STAT_CORR;
      end else begin
         status = STAT_UNCORR;
      end
   end

   // The flip mask holds the column syndrome in the byte that the row names.
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         stage_in.flip[i*BYTE_W +: BYTE_W] =
            (status == STAT_CORR && ys[i]) ? xs : '0;
      end
      stage_in.valid  = in_stage.valid;
      stage_in.data   = in_stage.data;
      stage_in.chk    = in_stage.chk;
      stage_in.status = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.data   <= stage_in.data;
      stage_ff.chk    <= stage_in.chk;
      stage_ff.flip   <= stage_in.flip;
      stage_ff.status <= stage_in.status;
   end

   assign out_stage = stage_ff;

endmodule

// File: hw/rtl/b2pe_fix.sv
// Third stage: apply the flip mask and hold the result word for one cycle.
module b2pe_fix import b2pe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  loc_stage_type      in_stage,
   output logic               out_valid,
   output logic [CHECK_W-1:0] out_check,
   output logic [DATA_W-1:0]  out_data,
   output logic [1:0]         out_status
);

   logic               valid_ff;
   logic [CHECK_W-1:0] check_ff;
   logic [DATA_W-1:0]  data_ff;
   logic [DATA_W-1:0]  data_in;
   status_type         status_ff;

   // A zero mask leaves the data as it arrived.
   assign data_in = in_stage.data ^ in_stage.flip;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_stage.valid;
      end
      check_ff  <= in_stage.chk;
      data_ff   <= data_in;
      status_ff <= in_stage.status;
   end

   assign out_valid  = valid_ff;
   assign out_check  = check_ff;
   assign out_data   = data_ff;
   assign out_status = status_ff;

endmodule

// File: hw/rtl/byte_block_2d_parity_ecc_core.sv
// Two-dimensional parity generator and single-bit corrector for a block of bytes.
// Request channel: drive req_type, req_data_block and req_received_check with
// start high; the word is taken at the rising edge where start is high and busy
// is low. busy is always low, so a new word may be sent in every cycle.
// req_type selects generate (check word only) or check (syndrome and repair).
// Result channel: rsp_valid is high for exactly one cycle with rsp_check_word,
// rsp_data_fixed and rsp_status; the receiver must take it in that cycle.
// A word taken at one edge is registered in the parity, locate and fix stages in turn
// and then shows on the result ports, where the receiver takes it.
// Throughput is one word per cycle, set by three register stages (parity,
// syndrome locate, data repair) that each take a new word every cycle.
// Reset clears the valid bits of all stages, so no result appears until a
// word is taken after reset. The receiver cannot stall, so there is no
// backpressure path and no word is ever held or dropped.
module byte_block_2d_parity_ecc_core import b2pe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [DATA_W-1:0]  req_data_block,
   input  logic [CHECK_W-1:0] req_received_check,
   output logic               rsp_valid,
   output logic [CHECK_W-1:0] rsp_check_word,
   output logic [DATA_W-1:0]  rsp_data_fixed,
   output logic [1:0]         rsp_status
);

   par_stage_type par_stage;
   loc_stage_type loc_stage;
   logic          accept;

   // Every stage advances every cycle, so the block never refuses a word.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   b2pe_parity u_parity (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_mode   (req_type),
      .in_data   (req_data_block),
      .in_rcv    (req_received_check),
      .out_stage (par_stage)
   );

   b2pe_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (par_stage),
      .out_stage (loc_stage)
   );

   b2pe_fix u_fix (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (loc_stage),
      .out_valid  (rsp_valid),
      .out_check  (rsp_check_word),
      .out_data   (rsp_data_fixed),
      .out_status (rsp_status)
   );

   // The result strobe matches the accepted word that has passed through every stage.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset, 1) && $past(!reset, 2) && $past(!reset, 3))
         |-> (rsp_valid == $past(accept, 3)))
      else $error("result strobe does not match accepted word three cycles back");

   // Data changes only when a correction is reported.
   a_data_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_CORR)
         |-> (rsp_data_fixed == $past(req_data_block, 3)))
      else $error("data altered without a reported correction");

   // A correction flips exactly one data bit.
   a_one_flip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_CORR)
         |-> ($countones(rsp_data_fixed ^ $past(req_data_block, 3)) == 1))
      else $error("correction did not flip exactly one bit");

   // Generate requests always report clean.
   a_gen_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_type, 3) == MODE_GEN) |-> (rsp_status == STAT_CLEAN))
      else $error("generate request reported a nonzero status");

endmodule
